// ===== rtl/swms_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// swms_pkg: shared constants for the sliding-window mean / stddev block
//
// Default sizes and the fixed widths of the result fields.
// ----------------------------------------------------------------------------
package swms_pkg;

    // default window length and sample width
    localparam int WINDOW_DEF      = 10;
    localparam int SAMPLE_BITS_DEF = 12;

    // result field widths (unsigned Q.8)
    localparam int MEAN_W   = 20;
    localparam int STDDEV_W = 19;

    // fraction bits of the results
    localparam int FRAC_W = 8;

endpackage : swms_pkg
`default_nettype wire

// ===== rtl/window_mean_stddev_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// window_mean_stddev_top: sliding-window mean and standard deviation
//
// Input channel s_*: one sample per item. Result channel m_*: one item per
// sample with the window mean and population stddev, both unsigned Q.8,
// floored. The sample replaces the oldest of WINDOW ring slots.
// One item is processed at a time. The square root yields R =
// SAMPLE_BITS + clog2(WINDOW) + 8 root bits (24 at the defaults). An item
// passes the states READ, SUMS, MUL, SPREAD, SQRT, DIV and OUT in turn.
// The bit-serial square root, one root bit per cycle, dominates the time
// per item; both divides by WINDOW are reciprocal multiplies, the mean
// divide starting in MUL, before the root. s_ready is high only while no
// item is in flight.
// The result sits in an output register: the next sample is accepted while
// it waits. If the receiver stalls, the following item finishes and holds
// until the output register frees up. Reset empties the ring (all slots read
// as zero), zeroes the running sums and the write slot, and drops m_valid.
// ----------------------------------------------------------------------------
module window_mean_stddev_top #(
    parameter int WINDOW      = swms_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = swms_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [SAMPLE_BITS-1:0]        s_sample,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic      [swms_pkg::MEAN_W-1:0]   m_mean_q8,
    output logic      [swms_pkg::STDDEV_W-1:0] m_stddev_q8
);

    localparam int ADDR_W = $clog2(WINDOW);
    localparam int SUM_W  = SAMPLE_BITS + ADDR_W;
    localparam int SQ1_W  = 2 * SAMPLE_BITS;
    localparam int SQS_W  = 2 * SAMPLE_BITS + ADDR_W;
    localparam int SPR_W  = 2 * SUM_W;
    localparam int FRAC_W = swms_pkg::FRAC_W;
    localparam int RAD_W  = SPR_W + 2 * FRAC_W;
    localparam int Q_W    = SUM_W + FRAC_W;

    // sequencer codes
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_READ   = 3'd1;
    localparam logic [2:0] ST_SUMS   = 3'd2;
    localparam logic [2:0] ST_MUL    = 3'd3;
    localparam logic [2:0] ST_SPREAD = 3'd4;
    localparam logic [2:0] ST_SQRT   = 3'd5;
    localparam logic [2:0] ST_DIV    = 3'd6;
    localparam logic [2:0] ST_OUT    = 3'd7;

    logic [2:0]              state_reg;
    logic [2:0]              state_next;
    logic [ADDR_W-1:0]       slot_reg;
    logic [SAMPLE_BITS-1:0]  sample_reg;
    logic [SQ1_W-1:0]        old_sq_reg;
    logic [SQ1_W-1:0]        new_sq_reg;
    logic [SAMPLE_BITS-1:0]  old_reg;
    logic [SUM_W-1:0]        sum_reg;
    logic [SQS_W-1:0]        sumsq_reg;
    logic [SPR_W-1:0]        sq_reg;
    logic [SPR_W-1:0]        wsq_reg;
    logic                    m_valid_reg;
    logic [swms_pkg::MEAN_W-1:0]   mean_reg;
    logic [swms_pkg::STDDEV_W-1:0] stddev_reg;

    logic                    accept;
    logic                    out_free;
    logic [SAMPLE_BITS-1:0]  ring_rd;
    logic [SPR_W-1:0]        spread;
    logic                    sqrt_start;
    logic                    sqrt_busy;
    logic [Q_W-1:0]          root;
    logic                    mean_start;
    logic                    mean_busy;
    logic [Q_W-1:0]          mean_quot;
    logic                    sd_start;
    logic                    sd_busy;
    logic [Q_W-1:0]          sd_quot;

    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);

    // ring memory: read the oldest slot on accept, write the new sample next cycle
    swms_ring #(
        .DEPTH  (WINDOW),
        .DATA_W (SAMPLE_BITS),
        .ADDR_W (ADDR_W)
    ) u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_en   (accept),
        .rd_addr (slot_reg),
        .rd_data (ring_rd),
        .wr_en   (state_reg == ST_READ),
        .wr_addr (slot_reg),
        .wr_data (sample_reg)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:   if (accept) state_next = ST_READ;
            ST_READ:   state_next = ST_SUMS;
            ST_SUMS:   state_next = ST_MUL;
            ST_MUL:    state_next = ST_SPREAD;
            ST_SPREAD: state_next = ST_SQRT;
            ST_SQRT:   if (!sqrt_busy) state_next = ST_DIV;
            ST_DIV:    if (!sd_busy && !mean_busy) state_next = ST_OUT;
            ST_OUT:    if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            slot_reg    <= '0;
            sum_reg     <= '0;
            sumsq_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            // write slot advances once the new sample is stored
            if (state_reg == ST_READ) begin
                slot_reg <= (slot_reg == ADDR_W'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
            end
            // running sums: drop the old sample, add the new one
            if (state_reg == ST_SUMS) begin
                sum_reg   <= sum_reg - SUM_W'(old_reg) + SUM_W'(sample_reg);
                sumsq_reg <= sumsq_reg - SQS_W'(old_sq_reg) + SQS_W'(new_sq_reg);
            end
            if (state_reg == ST_OUT && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            sample_reg <= s_sample;
        end
        // squares of the outgoing and incoming samples
        if (state_reg == ST_READ) begin
            old_reg    <= ring_rd;
            old_sq_reg <= SQ1_W'(ring_rd) * SQ1_W'(ring_rd);
            new_sq_reg <= SQ1_W'(sample_reg) * SQ1_W'(sample_reg);
        end
        // sum squared and WINDOW times the square sum
        if (state_reg == ST_MUL) begin
            sq_reg  <= SPR_W'(sum_reg) * SPR_W'(sum_reg);
            wsq_reg <= SPR_W'(sumsq_reg) * SPR_W'(WINDOW);
        end
        if (state_reg == ST_OUT && out_free) begin
            mean_reg   <= swms_pkg::MEAN_W'(mean_quot);
            stddev_reg <= swms_pkg::STDDEV_W'(sd_quot);
        end
    end

    // WINDOW^2 * variance, clamped at zero
    assign spread = (wsq_reg >= sq_reg) ? (wsq_reg - sq_reg) : '0;

    assign mean_start = (state_reg == ST_MUL);
    assign sqrt_start = (state_reg == ST_SPREAD);
    assign sd_start   = (state_reg == ST_SQRT) && !sqrt_busy;

    // mean: (sum << 8) / WINDOW
    swms_cdiv #(
        .NUM_W   (Q_W),
        .DIVISOR (WINDOW)
    ) u_mean_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mean_start),
        .num     ({sum_reg, FRAC_W'(0)}),
        .busy    (mean_busy),
        .quot    (mean_quot)
    );

    // root of (spread << 16)
    swms_isqrt #(
        .RAD_W (RAD_W)
    ) u_isqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start),
        .rad     ({spread, (2 * FRAC_W)'(0)}),
        .busy    (sqrt_busy),
        .root    (root)
    );

    // stddev: root / WINDOW
    swms_cdiv #(
        .NUM_W   (Q_W),
        .DIVISOR (WINDOW)
    ) u_sd_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sd_start),
        .num     (root),
        .busy    (sd_busy),
        .quot    (sd_quot)
    );

    assign m_valid     = m_valid_reg;
    assign m_mean_q8   = mean_reg;
    assign m_stddev_q8 = stddev_reg;

endmodule : window_mean_stddev_top
`default_nettype wire

// ===== rtl/swms_ring.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// swms_ring: sample ring memory
//
// One write port and one read port, read data registered.
// Per-entry valid bits make never-written slots read as zero after reset.
// ----------------------------------------------------------------------------
module swms_ring #(
    parameter int DEPTH  = swms_pkg::WINDOW_DEF,
    parameter int DATA_W = swms_pkg::SAMPLE_BITS_DEF,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic [DATA_W-1:0] rd_data_reg;
    logic              rd_valid_reg;

    // storage array, read-first on the registered port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // written-entry flags, cleared at reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule : swms_ring
`default_nettype wire

// ===== rtl/swms_isqrt.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// swms_isqrt: iterative integer square root
//
// Digit-by-digit method, one root bit per cycle. Result is floor(sqrt(rad)).
// ----------------------------------------------------------------------------
module swms_isqrt #(
    parameter int RAD_W = 48
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic [RAD_W-1:0]     rad,
    output logic                      busy,
    output logic      [RAD_W/2-1:0]   root
);

    localparam int ROOT_W = RAD_W / 2;
    localparam int REM_W  = ROOT_W + 2;
    localparam int CNT_W  = $clog2(ROOT_W + 1);

    logic [RAD_W-1:0]  rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic              take;

    // bring down the next two radicand bits and try a 1 digit
    always_comb begin
        rem_sh = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
        trial  = {root_reg, 2'b01};
        take   = (rem_sh >= trial);
    end

    // datapath, no reset needed
    always_ff @(posedge aclk) begin
        if (start) begin
            rad_reg  <= rad;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
            rem_reg  <= take ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[ROOT_W-2:0], take};
        end
    end

    // iteration count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_W'(ROOT_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule : swms_isqrt
`default_nettype wire

// ===== rtl/swms_cdiv.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// swms_cdiv: divider by a constant
//
// Reciprocal multiplication, floor result; num_reg then quot_reg are registered.
// ----------------------------------------------------------------------------
module swms_cdiv #(
    parameter int NUM_W   = 24,
    parameter int DIVISOR = swms_pkg::WINDOW_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [NUM_W-1:0] num,
    output logic                  busy,
    output logic      [NUM_W-1:0] quot
);

    // floor(x / DIVISOR) == (x * RECIP) >> SHIFT for every x below 2^NUM_W
    localparam int SHIFT  = NUM_W + $clog2(DIVISOR);
    localparam int PROD_W = 2 * NUM_W + 1;
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
    localparam logic [NUM_W:0] RECIP = (NUM_W + 1)'(RECIP_FULL);

    logic [NUM_W-1:0]  num_reg;
    logic [NUM_W-1:0]  quot_reg;
    logic              busy_reg;

    logic [PROD_W-1:0] prod;

    // NUM_W x (NUM_W+1) multiply by the scaled reciprocal
    always_comb begin
        prod = PROD_W'(num_reg) * PROD_W'(RECIP);
    end

    // capture the numerator, then the quotient in the cycle after
    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= num;
        end else if (busy_reg) begin
            quot_reg <= NUM_W'(prod >> SHIFT);
        end
    end

    // busy for the single multiply cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else begin
            busy_reg <= start;
        end
    end

    assign busy = busy_reg;
    assign quot = quot_reg;

endmodule : swms_cdiv
`default_nettype wire

// ===== rtl/swms_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// swms_checker: port-level checks for window_mean_stddev_top
//
// Watches the two channels only; attached to the top level by bind.
// ----------------------------------------------------------------------------
module swms_checker #(
    parameter int WINDOW      = swms_pkg::WINDOW_DEF,
    parameter int SAMPLE_BITS = swms_pkg::SAMPLE_BITS_DEF
) (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_valid,
    input wire logic                          s_ready,
    input wire logic [SAMPLE_BITS-1:0]        s_sample,
    input wire logic                          m_valid,
    input wire logic                          m_ready,
    input wire logic [swms_pkg::MEAN_W-1:0]   m_mean_q8,
    input wire logic [swms_pkg::STDDEV_W-1:0] m_stddev_q8
);

    localparam logic [39:0] SAMPLE_MAX = 40'((64'(1) << SAMPLE_BITS) - 1);
    localparam logic [39:0] MEAN_MAX   = SAMPLE_MAX << 8;
    localparam logic [39:0] SD_MAX     = SAMPLE_MAX << 7;

    // a stalled input item holds its value
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_sample))
        else $error("input item changed while stalled");

    // a stalled result item holds its value
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_mean_q8) && $stable(m_stddev_q8))
        else $error("result item changed while stalled");

    // one item in flight: ready drops right after an accept
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second item accepted while one is in flight");

    // no result can appear in the cycle after an accept
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !$rose(m_valid))
        else $error("result appeared too early");

    // mean never exceeds the largest sample; stddev never exceeds half of it
    a_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (40'(m_mean_q8) <= MEAN_MAX) && (40'(m_stddev_q8) <= SD_MAX))
        else $error("result out of range");

endmodule : swms_checker

bind window_mean_stddev_top swms_checker #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
) u_swms_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_sample    (s_sample),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_mean_q8   (m_mean_q8),
    .m_stddev_q8 (m_stddev_q8)
);
`default_nettype wire
